FILE: hdl/sust_pkg.sv
// Shared types and constants for the sorted unique set table.
// Used by the channel interfaces, front end, command queue, engine and top level.
package sust_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int KEY_W      = 16;
    localparam int POS_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    // Request codes as they arrive on the request channel
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT     = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE     = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP     = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ_POS   = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_POS = 3'd4;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_LOOKUP,
        OP_READ_POS,
        OP_REMOVE_POS,
        OP_NONE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_MISS,
        ST_FULL,
        ST_BADPOS
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_DECIDE,
        S_POS_RD,
        S_POS_CAP,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] position;
    } cmd_t;

endpackage

FILE: hdl/sust_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on sust_pkg for field widths.
interface sust_req_if import sust_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [KEY_W-1:0]      key;
    logic [POS_W-1:0]      position;

    modport source (output valid, req_type, key, position, input ready);
    modport sink   (input valid, req_type, key, position, output ready);
endinterface

interface sust_rsp_if import sust_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    value;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, status, value, count, input ready);
    modport sink   (input valid, status, value, count, output ready);
endinterface

FILE: hdl/sust_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sust_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/sust_front.sv
// Front end: accepts request items and classifies them into engine commands.
// Depends on sust_pkg and sust_req_if.
module sust_front import sust_pkg::*; (
    sust_req_if.sink req,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_ready
);

    op_t op;

    always_comb
    begin
        unique case (req.req_type)
            REQ_INSERT:     op = OP_INSERT;
            REQ_REMOVE:     op = OP_REMOVE;
            REQ_LOOKUP:     op = OP_LOOKUP;
            REQ_READ_POS:   op = OP_READ_POS;
            REQ_REMOVE_POS: op = OP_REMOVE_POS;
            default:        op = OP_NONE;
        endcase
    end

    assign cmd_valid    = req.valid;
    assign cmd.op       = op;
    assign cmd.key      = req.key;
    assign cmd.position = req.position;
    assign req.ready    = cmd_ready;

endmodule

FILE: hdl/sust_fifo.sv
// Two-entry command queue between the front end and the engine.
// Depends on sust_pkg for the command type.
module sust_fifo import sust_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  cmd_t in_cmd,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_cmd,
    input  logic out_ready
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hdl/sust_engine.sv
// Back end: runs one command at a time against the key RAM and registers the response.
// Depends on sust_pkg, sust_rsp_if and sust_ram.
module sust_engine import sust_pkg::*; #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_ready,
    sust_rsp_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    eng_state_t          state_reg;
    eng_state_t          state_next;
    op_t                 op_reg;
    op_t                 op_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       lo_next;
    logic [CW-1:0]       hi_reg;
    logic [CW-1:0]       hi_next;
    logic                hit_reg;
    logic                hit_next;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_next;
    logic                pend_reg;
    logic                pend_next;
    logic [AW-1:0]       wa_reg;
    logic [AW-1:0]       wa_next;
    status_t             status_reg;
    status_t             status_next;
    logic [KEY_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0] value_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             out_status_reg;
    status_t             out_status_next;
    logic [KEY_W-1:0]    out_value_reg;
    logic [KEY_W-1:0]    out_value_next;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [COUNT_W-1:0]  out_count_next;

    // RAM port controls
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    // Shared conditions
    logic [CW:0]                 mid_sum;
    logic [CW-1:0]               mid;
    logic [CW-1:0]               mid_inc;
    logic                        probe_more;
    logic                        table_full;
    logic [CW+POS_W-1:0]         pos_ext;
    logic [CW+POS_W-1:0]         cnt_ext;
    logic                        pos_ok;
    logic [CW-1:0]               pos_cw;
    logic [CW-1:0]               idx_dec;
    logic [CW-1:0]               idx_inc;
    logic                        up_more;
    logic                        dn_more;
    logic [KEY_BITS+KEY_W-1:0]   key_in_ext;
    logic [KEY_BITS+KEY_W-1:0]   value_ext;
    logic [CW+COUNT_W-1:0]       count_ext;
    logic                        out_free;

    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[CW:1];
    assign mid_inc    = mid + 1'b1;
    assign probe_more = (lo_reg < hi_reg);
    assign table_full = (count_reg == CW'(DEPTH));
    assign pos_ext    = {{CW{1'b0}}, pos_reg};
    assign cnt_ext    = {{POS_W{1'b0}}, count_reg};
    assign pos_ok     = (pos_ext < cnt_ext);
    assign pos_cw     = pos_ext[CW-1:0];
    assign idx_dec    = idx_reg - 1'b1;
    assign idx_inc    = idx_reg + 1'b1;
    assign up_more    = (idx_reg > lo_reg);
    assign dn_more    = (idx_reg < count_reg);
    assign key_in_ext = {{KEY_BITS{1'b0}}, cmd.key};
    assign value_ext  = {{KEY_W{1'b0}}, value_reg};
    assign count_ext  = {{COUNT_W{1'b0}}, count_reg};
    assign out_free   = !out_valid_reg || rsp.ready;

    assign cmd_ready  = (state_reg == S_IDLE);

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.count  = out_count_reg;

    sust_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_INSERT, OP_REMOVE, OP_LOOKUP: state_next = S_PROBE_RD;
                        OP_READ_POS, OP_REMOVE_POS:      state_next = S_POS_RD;
                        default:                         state_next = S_DONE;
                    endcase
                end
            end
            S_PROBE_RD:
            begin
                state_next = probe_more ? S_PROBE_CMP : S_DECIDE;
            end
            S_PROBE_CMP:
            begin
                state_next = S_PROBE_RD;
            end
            S_DECIDE:
            begin
                priority if (op_reg == OP_INSERT && !hit_reg && !table_full)
                begin
                    state_next = S_SHIFT_UP;
                end
                else if (op_reg == OP_REMOVE && hit_reg)
                begin
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POS_RD:
            begin
                state_next = pos_ok ? S_POS_CAP : S_DONE;
            end
            S_POS_CAP:
            begin
                state_next = (op_reg == OP_REMOVE_POS) ? S_SHIFT_DN : S_DONE;
            end
            S_SHIFT_UP:
            begin
                if (!up_more && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_DN:
            begin
                if (!dn_more && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM controls
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        hit_next        = hit_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        wa_next         = wa_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = wa_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = mid[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = cmd.op;
                    key_next    = key_in_ext[KEY_BITS-1:0];
                    pos_next    = cmd.position;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    hit_next    = 1'b0;
                    status_next = ST_MISS;
                    value_next  = '0;
                end
            end
            S_PROBE_RD:
            begin
                ram_re    = probe_more;
                ram_raddr = mid[AW-1:0];
            end
            S_PROBE_CMP:
            begin
                // Lower bound: keep the first cell not below the key
                if (ram_rdata < key_reg)
                begin
                    lo_next = mid_inc;
                end
                else
                begin
                    hi_next = mid;
                end
                if (ram_rdata == key_reg)
                begin
                    hit_next = 1'b1;
                end
            end
            S_DECIDE:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        priority if (hit_reg)
                        begin
                            status_next = ST_MISS;
                        end
                        else if (table_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            idx_next  = count_reg;
                            pend_next = 1'b0;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_OK;
                            idx_next    = lo_reg + 1'b1;
                            pend_next   = 1'b0;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        status_next = hit_reg ? ST_OK : ST_MISS;
                    end
                    default:
                    begin
                        status_next = ST_MISS;
                    end
                endcase
            end
            S_POS_RD:
            begin
                if (pos_ok)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_cw[AW-1:0];
                end
                else
                begin
                    status_next = ST_BADPOS;
                    value_next  = '0;
                end
            end
            S_POS_CAP:
            begin
                value_next  = ram_rdata;
                status_next = ST_OK;
                idx_next    = pos_cw + 1'b1;
                pend_next   = 1'b0;
            end
            S_SHIFT_UP:
            begin
                // Move cells up one place, top first; each write lags its registered read
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (up_more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[AW-1:0];
                    wa_next   = idx_reg[AW-1:0];
                    idx_next  = idx_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // Gap is open: drop the new key in
                        ram_we      = 1'b1;
                        ram_waddr   = lo_reg[AW-1:0];
                        ram_wdata   = key_reg;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_OK;
                    end
                end
            end
            S_SHIFT_DN:
            begin
                // Close the gap, bottom first
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (dn_more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[AW-1:0];
                    wa_next   = idx_dec[AW-1:0];
                    idx_next  = idx_inc;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_value_next  = value_ext[KEY_W-1:0];
                    out_count_next  = count_ext[COUNT_W-1:0];
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        hit_reg        <= hit_next;
        idx_reg        <= idx_next;
        wa_reg         <= wa_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

endmodule

FILE: hdl/sorted_unique_set_table_core.sv
// Sorted unique set table: up to DEPTH distinct keys kept in ascending order in a
// single-read, single-write RAM. Requests (insert, remove, lookup, read at position,
// remove at position) are decoded by a front end and queued two deep, so new requests
// are taken while the engine works and while a response waits on the output register.
// The engine runs one request at a time. A key request binary-searches the RAM, each
// probe a read state followed by a compare state; an insert or removal then moves
// every key above the affected position by one place at one key per cycle. The single
// RAM read port limits the search and the moves to one read at a time. The key store
// needs no clearing after reset: cells at or beyond the count are never read.
module sorted_unique_set_table_core import sust_pkg::*; #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sust_req_if.sink   req,
    sust_rsp_if.source rsp
);

    logic front_valid;
    cmd_t front_cmd;
    logic front_ready;
    logic queue_valid;
    cmd_t queue_cmd;
    logic queue_ready;

    sust_front u_front (
        .req       (req),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    sust_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_cmd    (front_cmd),
        .in_ready  (front_ready),
        .out_valid (queue_valid),
        .out_cmd   (queue_cmd),
        .out_ready (queue_ready)
    );

    sust_engine #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_ready (queue_ready),
        .rsp       (rsp)
    );

endmodule
